/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_ALWAYS(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_ALWAYS(label, (ante) |=> (cons), msg)

`endif

/* design/dhoat_pkg.sv */
// ----------------------------------------------------------------------------
// dhoat_pkg
// Widths, request/status/mark codes and controller-datapath structs.
// ----------------------------------------------------------------------------
package dhoat_pkg;

  localparam int SLOTS_DEF           = 16;
  localparam int KEY_BITS            = 32;
  localparam int VALUE_BITS          = 32;
  localparam int REQ_BITS            = 2;
  localparam int STATUS_BITS         = 3;
  localparam int MARK_BITS           = 2;
  // key bits folded into the residues per cycle
  localparam int HASH_BITS_PER_CYCLE = 4;

  localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd2;

  localparam logic [MARK_BITS-1:0] MARK_EMPTY    = 2'd0;
  localparam logic [MARK_BITS-1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [MARK_BITS-1:0] MARK_DELETED  = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic                   load;
    logic                   probe_start;
    logic                   probe_step;
    logic                   clear_step;
    logic                   wr_insert;
    logic                   wr_update;
    logic                   wr_remove;
    logic                   res_load;
    logic                   res_with_data;
    logic [STATUS_BITS-1:0] res_code;
    logic                   out_load;
  } cmd_t;

  typedef struct packed {
    logic                mod_done;
    logic [REQ_BITS-1:0] req;
    logic                hit;
    logic                empty;
    logic                free_any;
    logic                last;
    logic                clear_last;
  } stat_t;

endpackage

/* design/dhoat_ram.sv */
// ----------------------------------------------------------------------------
// dhoat_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dhoat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dhoat_hash.sv */
// ----------------------------------------------------------------------------
// dhoat_hash
// Iterative reduction of the key mod SLOTS and mod SLOTS-1, a few bits a cycle.
// ----------------------------------------------------------------------------
module dhoat_hash #(
  parameter int SLOTS = dhoat_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dhoat_pkg::KEY_BITS-1:0] key,
  output logic [$clog2(SLOTS)-1:0]      start_idx,
  output logic [$clog2(SLOTS)-1:0]      step,
  output logic                          done
);

  localparam int IW    = $clog2(SLOTS);
  localparam int BPC   = dhoat_pkg::HASH_BITS_PER_CYCLE;
  localparam int STEPS = (dhoat_pkg::KEY_BITS + BPC - 1) / BPC;
  localparam int KP    = STEPS * BPC;
  localparam int CNTW  = $clog2(STEPS + 1);
  localparam logic [IW:0] DIV_A = (IW+1)'(SLOTS);
  localparam logic [IW:0] DIV_B = (IW+1)'(SLOTS - 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [KP-1:0]   shreg;
  logic [IW-1:0]   rem_a;
  logic [IW-1:0]   rem_b;
  logic [IW-1:0]   rem_a_next;
  logic [IW-1:0]   rem_b_next;

  // shift-subtract: residue stays below the divisor, so one compare per bit
  always_comb begin
    logic [IW:0] ta;
    logic [IW:0] tb;
    rem_a_next = rem_a;
    rem_b_next = rem_b;
    for (int i = 0; i < BPC; i++) begin
      ta = {rem_a_next, shreg[KP-1-i]};
      tb = {rem_b_next, shreg[KP-1-i]};
      if (ta >= DIV_A) begin
        ta = ta - DIV_A;
      end
      if (tb >= DIV_B) begin
        tb = tb - DIV_B;
      end
      rem_a_next = ta[IW-1:0];
      rem_b_next = tb[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= KP'(key);
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      shreg <= shreg << BPC;
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

  assign start_idx = rem_a;
  assign step      = rem_b + IW'(1);

endmodule

/* design/dhoat_dp.sv */
// ----------------------------------------------------------------------------
// dhoat_dp
// Datapath: request registers, probe walker, slot stores, result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhoat_dp #(
  parameter int SLOTS = dhoat_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dhoat_pkg::cmd_t                    cmd,
  output dhoat_pkg::stat_t                   stat,
  input  logic [dhoat_pkg::REQ_BITS-1:0]     req_type,
  input  logic [dhoat_pkg::KEY_BITS-1:0]     key,
  input  logic [dhoat_pkg::VALUE_BITS-1:0]   new_value,
  output logic [dhoat_pkg::STATUS_BITS-1:0]  status,
  output logic [dhoat_pkg::VALUE_BITS-1:0]   read_value,
  output logic [$clog2(SLOTS+1)-1:0]         occupied_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [dhoat_pkg::REQ_BITS-1:0]    req_q;
  logic [dhoat_pkg::KEY_BITS-1:0]    key_q;
  logic [dhoat_pkg::VALUE_BITS-1:0]  value_q;
  logic [IW-1:0]                     probe_idx;
  logic [IW-1:0]                     pcnt;
  logic [IW-1:0]                     chk_idx;
  logic [IW-1:0]                     chk_cnt;
  logic                              chk_valid;
  logic                              free_seen;
  logic [IW-1:0]                     free_idx;
  logic [IW-1:0]                     free_sel;
  logic [CW-1:0]                     count;
  logic [IW-1:0]                     clr_idx;
  logic [dhoat_pkg::STATUS_BITS-1:0] res_status;
  logic [dhoat_pkg::VALUE_BITS-1:0]  res_value;

  logic [IW-1:0]                     h_start;
  logic [IW-1:0]                     h_step;
  logic                              h_done;
  logic [IW:0]                       psum;
  logic [IW-1:0]                     probe_adv;

  logic                              mark_we;
  logic [IW-1:0]                     mark_waddr;
  logic [dhoat_pkg::MARK_BITS-1:0]   mark_wdata;
  logic [dhoat_pkg::MARK_BITS-1:0]   mark_rd;
  logic [dhoat_pkg::KEY_BITS-1:0]    key_rd;
  logic                              data_we;
  logic [IW-1:0]                     data_waddr;
  logic [dhoat_pkg::VALUE_BITS-1:0]  data_rd;

  dhoat_hash #(.SLOTS(SLOTS)) u_hash (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .key       (key),
    .start_idx (h_start),
    .step      (h_step),
    .done      (h_done)
  );

  // next probe, sum stays below 2*SLOTS
  assign psum      = {1'b0, probe_idx} + {1'b0, h_step};
  assign probe_adv = (psum >= (IW+1)'(SLOTS)) ? IW'(psum - (IW+1)'(SLOTS)) : psum[IW-1:0];

  assign free_sel = free_seen ? free_idx : chk_idx;

  always_comb begin
    mark_we    = cmd.clear_step | cmd.wr_insert | cmd.wr_remove;
    mark_waddr = chk_idx;
    mark_wdata = dhoat_pkg::MARK_DELETED;
    if (cmd.clear_step) begin
      mark_waddr = clr_idx;
      mark_wdata = dhoat_pkg::MARK_EMPTY;
    end else if (cmd.wr_insert) begin
      mark_waddr = free_sel;
      mark_wdata = dhoat_pkg::MARK_OCCUPIED;
    end
    data_we    = cmd.wr_insert | cmd.wr_update;
    data_waddr = cmd.wr_insert ? free_sel : chk_idx;
  end

  dhoat_ram #(.WIDTH(dhoat_pkg::MARK_BITS), .DEPTH(SLOTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (probe_idx),
    .rdata (mark_rd)
  );

  dhoat_ram #(.WIDTH(dhoat_pkg::KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.wr_insert),
    .waddr (free_sel),
    .wdata (key_q),
    .raddr (probe_idx),
    .rdata (key_rd)
  );

  dhoat_ram #(.WIDTH(dhoat_pkg::VALUE_BITS), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (value_q),
    .raddr (probe_idx),
    .rdata (data_rd)
  );

  always_comb begin
    stat.mod_done   = h_done;
    stat.req        = req_q;
    stat.hit        = chk_valid && (mark_rd == dhoat_pkg::MARK_OCCUPIED) && (key_rd == key_q);
    stat.empty      = chk_valid && (mark_rd == dhoat_pkg::MARK_EMPTY);
    stat.free_any   = free_seen || (chk_valid && (mark_rd != dhoat_pkg::MARK_OCCUPIED));
    stat.last       = chk_valid && (chk_cnt == IW'(SLOTS - 1));
    stat.clear_last = (clr_idx == IW'(SLOTS - 1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      free_seen <= 1'b0;
      count     <= '0;
      clr_idx   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (cmd.probe_start) begin
        chk_valid <= 1'b0;
        free_seen <= 1'b0;
      end else if (cmd.probe_step) begin
        chk_valid <= 1'b1;
        if (chk_valid && (mark_rd != dhoat_pkg::MARK_OCCUPIED)) begin
          free_seen <= 1'b1;
        end
      end
      if (cmd.wr_insert) begin
        count <= count + CW'(1);
      end else if (cmd.wr_remove && (count != '0)) begin
        count <= count - CW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_type;
      key_q   <= key;
      value_q <= new_value;
    end
    if (cmd.probe_start) begin
      probe_idx <= h_start;
      pcnt      <= '0;
    end else if (cmd.probe_step) begin
      probe_idx <= probe_adv;
      pcnt      <= pcnt + IW'(1);
      chk_idx   <= probe_idx;
      chk_cnt   <= pcnt;
      if (chk_valid && !free_seen && (mark_rd != dhoat_pkg::MARK_OCCUPIED)) begin
        free_idx <= chk_idx;
      end
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_value  <= cmd.res_with_data ? data_rd : '0;
    end
    if (cmd.out_load) begin
      status         <= res_status;
      read_value     <= res_value;
      occupied_count <= count;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= CW'(SLOTS), "occupied count above table size")
  `ASSERT_IMPL(a_insert_has_free, cmd.wr_insert, stat.free_any && !stat.hit, "insert without free probe")

endmodule

/* design/dhoat_ctrl.sv */
// ----------------------------------------------------------------------------
// dhoat_ctrl
// Controller: clearing pass, request sequencing, probe decisions, handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhoat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output dhoat_pkg::cmd_t  cmd,
  input  dhoat_pkg::stat_t stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.mod_done) begin
          if (stat.req inside {dhoat_pkg::REQ_INSERT, dhoat_pkg::REQ_FIND,
                               dhoat_pkg::REQ_REMOVE}) begin
            cmd.probe_start = 1'b1;
            state_next      = S_SCAN;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = dhoat_pkg::ST_NOT_FOUND;
            state_next   = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.probe_step = 1'b1;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
          case (stat.req)
            dhoat_pkg::REQ_INSERT: begin
              cmd.wr_update = 1'b1;
              cmd.res_code  = dhoat_pkg::ST_UPDATED;
            end
            dhoat_pkg::REQ_FIND: begin
              cmd.res_with_data = 1'b1;
              cmd.res_code      = dhoat_pkg::ST_FOUND;
            end
            default: begin
              cmd.wr_remove = 1'b1;
              cmd.res_code  = dhoat_pkg::ST_REMOVED;
            end
          endcase
        end else if (stat.empty && (stat.req != dhoat_pkg::REQ_INSERT)) begin
          cmd.res_load = 1'b1;
          cmd.res_code = dhoat_pkg::ST_NOT_FOUND;
          state_next   = S_DONE;
        end else if (stat.last) begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
          if (stat.req != dhoat_pkg::REQ_INSERT) begin
            cmd.res_code = dhoat_pkg::ST_NOT_FOUND;
          end else if (stat.free_any) begin
            cmd.wr_insert = 1'b1;
            cmd.res_code  = dhoat_pkg::ST_INSERTED;
          end else begin
            cmd.res_code = dhoat_pkg::ST_FULL;
          end
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_accept_hash, in_valid && !in_stall, state == S_HASH, "accepted request not hashed")
  `ASSERT_IMPL(a_write_in_scan, cmd.wr_insert || cmd.wr_update || cmd.wr_remove, state == S_SCAN, "slot write outside probe walk")
  `ASSERT_IMPL(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "result raised outside completion")

endmodule

/* design/double_hash_open_address_table.sv */
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Open-addressed key/value table with double-hashing probe sequence.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    req_type, key, new_value
//  output    out_valid / out_stall  status, read_value, occupied_count
//
// After reset the slot marks are cleared one slot at a time; input is stalled then.
// A request first has its key reduced by the hash unit, then walks one probe per
// cycle through the slot RAM read port (at most SLOTS probes, with a registered
// read), then loads its result into the output register.
// A held output stall keeps the finished result and holds off the next one.
// ----------------------------------------------------------------------------
module double_hash_open_address_table #(
  parameter int SLOTS = dhoat_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dhoat_pkg::REQ_BITS-1:0]     req_type,
  input  logic [dhoat_pkg::KEY_BITS-1:0]     key,
  input  logic [dhoat_pkg::VALUE_BITS-1:0]   new_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dhoat_pkg::STATUS_BITS-1:0]  status,
  output logic [dhoat_pkg::VALUE_BITS-1:0]   read_value,
  output logic [$clog2(SLOTS+1)-1:0]         occupied_count
);

  dhoat_pkg::cmd_t  cmd;
  dhoat_pkg::stat_t stat;

  dhoat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  dhoat_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .key            (key),
    .new_value      (new_value),
    .status         (status),
    .read_value     (read_value),
    .occupied_count (occupied_count)
  );

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-hashing key/value table. Requests go in
// over the valid/stall input channel. A shadow copy of the table predicts
// status, read value and occupancy for each accepted transaction. Each result
// is checked in order against that prediction. Covers extreme keys and
// values, the unused request code, a short probe cycle that reports full
// while slots are still free, random traffic with idling and stalls, a long
// output hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_SLOTS   = dhoat_pkg::SLOTS_DEF;
  localparam int COUNT_BITS    = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_POOL_SIZE = 20;
  localparam int HOLD_CYCLES   = 500;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  // request code that the block does not decode
  localparam logic [dhoat_pkg::REQ_BITS-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [dhoat_pkg::STATUS_BITS-1:0] status;
    logic [dhoat_pkg::VALUE_BITS-1:0]  value;
    logic [COUNT_BITS-1:0]             count;
  } table_result_t;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic [dhoat_pkg::REQ_BITS-1:0]    req_type       = '0;
  logic [dhoat_pkg::KEY_BITS-1:0]    key            = '0;
  logic [dhoat_pkg::VALUE_BITS-1:0]  new_value      = '0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic [dhoat_pkg::STATUS_BITS-1:0] status;
  logic [dhoat_pkg::VALUE_BITS-1:0]  read_value;
  logic [COUNT_BITS-1:0]             occupied_count;

  // shadow copy of the table
  logic [dhoat_pkg::KEY_BITS-1:0]    shadow_key   [TABLE_SLOTS];
  logic [dhoat_pkg::VALUE_BITS-1:0]  shadow_value [TABLE_SLOTS];
  logic [dhoat_pkg::MARK_BITS-1:0]   shadow_mark  [TABLE_SLOTS];
  int unsigned                       shadow_count = 0;

  table_result_t                     pending_results[$];
  logic [dhoat_pkg::KEY_BITS-1:0]    key_pool[KEY_POOL_SIZE];

  int          error_count  = 0;
  int unsigned cycle_count  = 0;
  bit          gaps_on      = 1'b0;
  logic        stall_on     = 1'b0;
  int unsigned hold_trigger = 0;

  double_hash_open_address_table #(
    .SLOTS(TABLE_SLOTS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .key           (key),
    .new_value     (new_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .read_value    (read_value),
    .occupied_count(occupied_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- shadow table ----

  // Walk the double-hash probe sequence for an occupied slot holding k.
  function automatic int locate_key(logic [dhoat_pkg::KEY_BITS-1:0] k, bit stop_on_empty);
    int idx;
    int step;
    idx  = k % TABLE_SLOTS;
    step = 1 + k % (TABLE_SLOTS - 1);
    for (int a = 0; a < TABLE_SLOTS; a++) begin
      if (stop_on_empty && shadow_mark[idx] == dhoat_pkg::MARK_EMPTY) return TABLE_SLOTS;
      if (shadow_mark[idx] == dhoat_pkg::MARK_OCCUPIED && shadow_key[idx] == k) return idx;
      idx = (idx + step) % TABLE_SLOTS;
    end
    return TABLE_SLOTS;
  endfunction

  function automatic int first_free_probe(logic [dhoat_pkg::KEY_BITS-1:0] k);
    int idx;
    int step;
    idx  = k % TABLE_SLOTS;
    step = 1 + k % (TABLE_SLOTS - 1);
    for (int a = 0; a < TABLE_SLOTS; a++) begin
      if (shadow_mark[idx] != dhoat_pkg::MARK_OCCUPIED) return idx;
      idx = (idx + step) % TABLE_SLOTS;
    end
    return TABLE_SLOTS;
  endfunction

  function automatic table_result_t apply_request(logic [dhoat_pkg::REQ_BITS-1:0] req,
                                                  logic [dhoat_pkg::KEY_BITS-1:0] k,
                                                  logic [dhoat_pkg::VALUE_BITS-1:0] v);
    table_result_t res;
    int idx;
    res.status = dhoat_pkg::ST_NOT_FOUND;
    res.value  = '0;
    case (req)
      dhoat_pkg::REQ_INSERT: begin
        idx = locate_key(k, 1'b0);
        if (idx < TABLE_SLOTS) begin
          shadow_value[idx] = v;
          res.status = dhoat_pkg::ST_UPDATED;
        end else begin
          idx = first_free_probe(k);
          if (idx < TABLE_SLOTS) begin
            shadow_key[idx]   = k;
            shadow_value[idx] = v;
            shadow_mark[idx]  = dhoat_pkg::MARK_OCCUPIED;
            shadow_count++;
            res.status = dhoat_pkg::ST_INSERTED;
          end else begin
            res.status = dhoat_pkg::ST_FULL;
          end
        end
      end
      dhoat_pkg::REQ_FIND: begin
        idx = locate_key(k, 1'b1);
        if (idx < TABLE_SLOTS) begin
          res.value  = shadow_value[idx];
          res.status = dhoat_pkg::ST_FOUND;
        end
      end
      dhoat_pkg::REQ_REMOVE: begin
        idx = locate_key(k, 1'b1);
        if (idx < TABLE_SLOTS) begin
          shadow_mark[idx] = dhoat_pkg::MARK_DELETED;
          if (shadow_count > 0) shadow_count--;
          res.status = dhoat_pkg::ST_REMOVED;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[COUNT_BITS-1:0];
    return res;
  endfunction

  // ---- output side ----

  // Random stalls, plus a long hold-off each time hold_trigger moves on.
  always @(posedge clk) begin : drive_out_stall
    int unsigned hold_seen;
    int          hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen = hold_trigger;
      hold_left = 0;
    end else begin
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %h count %0d",
                 $time, status, read_value, occupied_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
          error_count++;
        end
        if (read_value !== want.value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, want.value, read_value);
          error_count++;
        end
        if (occupied_count !== want.count) begin
          $display("%0t: occupied_count mismatch, expected %0d, actual %0d",
                   $time, want.count, occupied_count);
          error_count++;
        end
      end
    end
  end

  // ---- input side ----

  // Leaves in_valid high so a following transaction can go out back to back.
  task automatic issue_request(logic [dhoat_pkg::REQ_BITS-1:0] req,
                               logic [dhoat_pkg::KEY_BITS-1:0] k,
                               logic [dhoat_pkg::VALUE_BITS-1:0] v);
    if (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    key       <= k;
    new_value <= v;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, apply_request(req, k, v)};
  endtask

  // Drops in_valid and always waits on the clock, so the next drive lands in a fresh step.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic issue_random_request();
    logic [dhoat_pkg::REQ_BITS-1:0] req;
    logic [dhoat_pkg::KEY_BITS-1:0] k;
    int                             pick;
    pick = $urandom_range(99);
    if (pick < 40)      req = dhoat_pkg::REQ_INSERT;
    else if (pick < 70) req = dhoat_pkg::REQ_FIND;
    else if (pick < 95) req = dhoat_pkg::REQ_REMOVE;
    else                req = REQ_UNUSED;
    // mostly keys from a small pool so that hits, updates and removes happen
    if ($urandom_range(9) == 0) k = $urandom;
    else                        k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    issue_request(req, k, $urandom);
  endtask

  // ---- tests ----

  task automatic test_extremes_and_codes();
    issue_request(dhoat_pkg::REQ_INSERT, '1, '1);
    issue_request(dhoat_pkg::REQ_FIND,   '1, '0);
    issue_request(dhoat_pkg::REQ_INSERT, '1, '0);
    issue_request(dhoat_pkg::REQ_FIND,   '1, '1);
    issue_request(dhoat_pkg::REQ_REMOVE, '1, '0);
    issue_request(dhoat_pkg::REQ_FIND,   '1, '0);
    issue_request(REQ_UNUSED,            '0, '1);
    issue_request(dhoat_pkg::REQ_REMOVE, '0, '0);
    wait_results_drained();
  endtask

  // Key 16 starts at slot 0 with step 2, so it only sees the even slots.
  task automatic test_short_probe_cycle();
    for (int i = 0; i < TABLE_SLOTS; i += 2) issue_request(dhoat_pkg::REQ_INSERT, i, $urandom);
    issue_request(dhoat_pkg::REQ_INSERT, 32'd16, $urandom);
    issue_request(dhoat_pkg::REQ_FIND,   32'd16, '0);
    issue_request(dhoat_pkg::REQ_REMOVE, 32'd16, '0);
    issue_request(dhoat_pkg::REQ_REMOVE, 32'd2,  '0);
    issue_request(dhoat_pkg::REQ_INSERT, 32'd16, $urandom);
    issue_request(dhoat_pkg::REQ_FIND,   32'd16, '0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int n);
    gaps_on = 1'b1;
    stall_on <= 1'b1;
    repeat (n) issue_random_request();
    wait_results_drained();
  endtask

  task automatic test_no_idle_stretch(int n);
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    repeat (n) issue_random_request();
    wait_results_drained();
  endtask

  // Output held off for a long while; input must back up and stall.
  task automatic test_output_hold_off(int n);
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    hold_trigger <= hold_trigger + 1;
    repeat (n) issue_random_request();
    wait_results_drained();
  endtask

  // Sender stops until every result is back, then carries on.
  task automatic test_sender_pause(int n);
    gaps_on = 1'b1;
    stall_on <= 1'b1;
    repeat (n) issue_random_request();
    wait_results_drained();
    repeat (n) issue_random_request();
    wait_results_drained();
  endtask

  initial begin
    foreach (shadow_mark[i]) begin
      shadow_mark[i]  = dhoat_pkg::MARK_EMPTY;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    for (int i = 0; i < KEY_POOL_SIZE; i++)
      key_pool[i] = (i < 9) ? 2 * i : $urandom;
    key_pool[KEY_POOL_SIZE - 1] = '1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_extremes_and_codes();
    test_short_probe_cycle();
    test_random_traffic(500);
    test_no_idle_stretch(200);
    test_output_hold_off(40);
    test_sender_pause(30);
    test_random_traffic(400);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
